### hdl/p1305_pkg.sv
// Shared constants, types and the block formatting function for the Poly1305 core.
package p1305_pkg;

	// prime 2^130 - 5 and its multiples, in the widths the datapath uses
	localparam logic [129:0] P      = 130'h3fffffffffffffffffffffffffffffffb;
	localparam logic [130:0] P2     = {P, 1'b0};
	localparam logic [131:0] NEG_P  = ~{2'b00, P} + 132'd1;
	localparam logic [131:0] NEG_2P = ~{1'b0, P2} + 132'd1;

	localparam logic [127:0] R_CLAMP = 128'h0ffffffc0ffffffc0ffffffc0fffffff;
	localparam logic [127:0] S_FULL  = 128'hffffffffffffffffffffffffffffffff;

	// clamped r has bits 127..124 clear, so the multiply walks bits 123..0
	localparam int unsigned R_BITS = 124;
	localparam int unsigned CNT_W  = $clog2(R_BITS);

	localparam int unsigned ADDR_W = 5;
	localparam logic [1:0] REG_R_LOW  = 2'd0;
	localparam logic [1:0] REG_R_HIGH = 2'd1;
	localparam logic [1:0] REG_S_LOW  = 2'd2;
	localparam logic [1:0] REG_S_HIGH = 2'd3;

	localparam logic [4:0] FULL_COUNT = 5'd16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_PREP,
		ST_MUL,
		ST_DONE
	} state_t;

	// message word with the 0x01 pad byte placed after the last valid byte
	function automatic logic [128:0] blk_fmt(input logic [63:0] lo, input logic [63:0] hi,
			input logic [4:0] cnt);
		logic [4:0]   n;
		logic [7:0]   sh;
		logic [128:0] pad;
		n   = (cnt > FULL_COUNT) ? FULL_COUNT : cnt;
		sh  = {n, 3'b000};
		pad = 129'd1 << sh;
		return ({1'b0, hi, lo} & (pad - 129'd1)) | pad;
	endfunction

endpackage

### hdl/p1305_if.sv
// Valid/ready channels for message words and tag words.
interface p1305_msg_if;
	logic        valid;
	logic        ready;
	logic [63:0] block_low;
	logic [63:0] block_high;
	logic [4:0]  byte_count;
	logic        last_block;

	modport source (output valid, block_low, block_high, byte_count, last_block, input ready);
	modport sink   (input valid, block_low, block_high, byte_count, last_block, output ready);
endinterface

interface p1305_tag_if;
	logic        valid;
	logic        ready;
	logic [63:0] tag_low;
	logic [63:0] tag_high;

	modport source (output valid, tag_low, tag_high, input ready);
	modport sink   (input valid, tag_low, tag_high, output ready);
endinterface

### hdl/poly1305_mac_core.sv
// Poly1305 MAC core: one message word per item, tag word after the last one.
// Each accepted word goes through reduce, prepare, 124 multiply steps and finish; a
// new word is taken only after the previous one is done, and finish holds while an
// earlier tag waits. The modular multiply is bit-serial, one bit of clamped r per cycle.
// Reset: asynchronous, active low; clears keys, accumulator, state and output valid.
module poly1305_mac_core
	import p1305_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready,
	p1305_msg_if.sink         msg,
	p1305_tag_if.source       tag
);

	state_t state_q, state_d;

	logic [63:0]      r_low_q, r_high_q, s_low_q, s_high_q;
	logic [129:0]     acc_q;
	logic [130:0]     sum_q;
	logic [129:0]     h_q;
	logic [131:0]     hp1_q, hp2_q;
	logic [129:0]     x_q;
	logic [R_BITS-1:0] r_sh_q;
	logic [CNT_W-1:0] cnt_q;
	logic             last_q;
	logic             out_valid_q;
	logic [127:0]     tag_q;

	logic             cfg_wr;
	logic [127:0]     r_clamped;
	logic [131:0]     a0, a1, a2, dbl, c0, c1, c2;
	logic [129:0]     x_next;
	logic             emit;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_low_q  <= '0;
			r_high_q <= '0;
			s_low_q  <= '0;
			s_high_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:3])
				REG_R_LOW:  r_low_q  <= pwdata;
				REG_R_HIGH: r_high_q <= pwdata;
				REG_S_LOW:  s_low_q  <= pwdata;
				REG_S_HIGH: s_high_q <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			REG_R_LOW:  prdata = r_low_q;
			REG_R_HIGH: prdata = r_high_q;
			REG_S_LOW:  prdata = s_low_q;
			REG_S_HIGH: prdata = s_high_q;
		endcase
	end

	assign r_clamped = {r_high_q, r_low_q} & R_CLAMP;

	// ---------------- multiply step: x = (2x + bit*h) mod p ----------------
	// all three reductions are tried at once; the smallest nonnegative one wins
	assign a0  = r_sh_q[R_BITS-1] ? {2'b00, h_q} : '0;
	assign a1  = r_sh_q[R_BITS-1] ? hp1_q : NEG_P;
	assign a2  = r_sh_q[R_BITS-1] ? hp2_q : NEG_2P;
	assign dbl = {1'b0, x_q, 1'b0};
	assign c0  = dbl + a0;
	assign c1  = dbl + a1;
	assign c2  = dbl + a2;

	always_comb begin
		priority if (!c2[131]) begin
			x_next = c2[129:0];
		end else if (!c1[131]) begin
			x_next = c1[129:0];
		end else begin
			x_next = c0[129:0];
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		msg.ready = 1'b0;
		emit      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				msg.ready = 1'b1;
				if (msg.valid) begin
					state_d = ST_REDUCE;
				end
			end
			ST_REDUCE: state_d = ST_PREP;
			ST_PREP:   state_d = ST_MUL;
			ST_MUL: begin
				if (cnt_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold while an earlier tag still waits
				if (!last_q) begin
					state_d = ST_IDLE;
				end else if (!out_valid_q || tag.ready) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------- accumulator and datapath ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (state_q == ST_DONE && state_d == ST_IDLE) begin
			acc_q <= last_q ? '0 : x_q;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				sum_q  <= {1'b0, acc_q}
					+ {2'b00, blk_fmt(msg.block_low, msg.block_high, msg.byte_count)};
				last_q <= msg.last_block;
			end
			ST_REDUCE: begin
				// acc + block stays below 2p, one subtraction is enough
				h_q    <= (sum_q >= {1'b0, P}) ? 130'(sum_q - {1'b0, P}) : sum_q[129:0];
				r_sh_q <= r_clamped[R_BITS-1:0];
			end
			ST_PREP: begin
				hp1_q <= {2'b00, h_q} + NEG_P;
				hp2_q <= {2'b00, h_q} + NEG_2P;
				x_q   <= '0;
				cnt_q <= CNT_W'(R_BITS - 1);
			end
			ST_MUL: begin
				x_q    <= x_next;
				r_sh_q <= {r_sh_q[R_BITS-2:0], 1'b0};
				cnt_q  <= cnt_q - CNT_W'(1);
			end
			ST_DONE: begin
				if (emit) begin
					tag_q <= (x_q[127:0] + {s_high_q, s_low_q}) & S_FULL;
				end
			end
			default: begin
			end
		endcase
	end

	// ---------------- output word ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (tag.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign tag.valid    = out_valid_q;
	assign tag.tag_low  = tag_q[63:0];
	assign tag.tag_high = tag_q[127:64];

endmodule
